@@ design/ibd_pkg.sv @@
// ibd_pkg: shared widths, register indexes, handshake structs and helpers
// for the i/q boxcar decimator; no dependencies

package ibd_pkg;

  localparam int SMP_W               = 8;   // offset-binary sample width
  localparam int SUM_W               = 12;  // saturating accumulator width
  localparam int N_W                 = 5;   // decimation factor and pair counter
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_W               = 5;   // widest register
  localparam int MAX_DECIMATION_DEF  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_MODE  = 2'd1;

  // request to the shared serial divider
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [N_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  // finished result handed to the output register
  typedef struct packed {
    logic                    valid;
    logic signed [SMP_W-1:0] i;
    logic signed [SMP_W-1:0] q;
  } res_t;

  // offset binary to two's complement: subtract 128 mod 256
  function automatic logic signed [SMP_W-1:0] to_signed8(input logic [SMP_W-1:0] v);
    return {~v[SMP_W-1], v[SMP_W-2:0]};
  endfunction

  // clamp a quotient to the sample range
  function automatic logic [SMP_W-1:0] sat8(input logic [SUM_W-1:0] v);
    logic [SMP_W-1:0] r;
    r = (|v[SUM_W-1:SMP_W]) ? {SMP_W{1'b1}} : v[SMP_W-1:0];
    return r;
  endfunction

endpackage

@@ design/iq_boxcar_decimator_core.sv @@
// iq_boxcar_decimator_core: top level, output register plus the sequencer
// and shared divider; depends on ibd_pkg, ibd_divider, ibd_ctrl
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tdata[15:0] = {sample_q, sample_i}
//  m_axis    out        tvalid / tready        tdata[15:0] = {out_q, out_i}
//  cfg       in         we (no wait)           addr[1:0], wdata[4:0]
//
// a pair that does not close a group, and a dropped pair in skip mode, is absorbed in idle;
// a kept pair in skip mode holds the input in the emit state until the result moves out
// a pair that closes an averaging group waits on the one serial divider, which
// yields one quotient bit a cycle, 12 bits for i and then 12 for q, between accept and handoff
// a stalled output holds the finished result in the sequencer until the register frees
// reset clears the sums, the group counter and sets decimation to 1, averaging mode

module iq_boxcar_decimator_core import ibd_pkg::*; #(
  parameter int MAX_DECIMATION = MAX_DECIMATION_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [2*SMP_W-1:0]   s_axis_tdata,   // [7:0] sample_i, [15:8] sample_q
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*SMP_W-1:0]   m_axis_tdata,   // [7:0] out_i, [15:8] out_q
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  res_t                res;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                slot_free;
  logic                out_valid_q, out_valid_d;
  logic [2*SMP_W-1:0]  out_data_q, out_data_d;

  ibd_ctrl #(
    .MAX_DECIMATION(MAX_DECIMATION)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i_i  (s_axis_tdata[SMP_W-1:0]),
    .sample_q_i  (s_axis_tdata[2*SMP_W-1:SMP_W]),
    .res_o       (res),
    .res_ready_i (slot_free),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  ibd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign slot_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res.valid && slot_free) begin
      out_valid_d = 1'b1;
      out_data_d  = {res.q, res.i};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ design/ibd_divider.sv @@
// ibd_divider: restoring divider, one quotient bit per cycle
// depends on ibd_pkg

module ibd_divider import ibd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [3:0] LAST_STEP = 4'(SUM_W - 1);

  logic             busy_q, busy_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [SUM_W-1:0] dvd_q, dvd_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [N_W-1:0]   rem_q, rem_d;
  logic [N_W-1:0]   dsr_q, dsr_d;
  logic [N_W:0]     shifted;
  logic [N_W:0]     diff;
  logic             ge;

  assign shifted = {rem_q, dvd_q[SUM_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign ge      = (shifted >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      quo_d  = '0;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[N_W-1:0] : shifted[N_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], ge};
      dvd_d = {dvd_q[SUM_W-2:0], 1'b0};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
      end
    end
  end

  assign rsp_o.done     = busy_q && (cnt_q == LAST_STEP);
  assign rsp_o.quotient = {quo_q[SUM_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

endmodule

@@ design/ibd_ctrl.sv @@
// ibd_ctrl: configuration registers, accumulators, group counter and the
// sequencer that drives the shared divider; depends on ibd_pkg

module ibd_ctrl import ibd_pkg::*; #(
  parameter int MAX_DECIMATION = MAX_DECIMATION_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SMP_W-1:0]     sample_i_i,
  input  logic [SMP_W-1:0]     sample_q_i,
  output res_t                 res_o,
  input  logic                 res_ready_i,
  output div_req_t             div_req_o,
  input  div_rsp_t             div_rsp_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV_I = 4'b0010,
    ST_DIV_Q = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [N_W-1:0]          dec_q, dec_d;
  logic                    skip_q, skip_d;
  logic [SUM_W-1:0]        sum_i_q, sum_i_d;
  logic [SUM_W-1:0]        sum_q_q, sum_q_d;
  logic [N_W-1:0]          seen_q, seen_d;
  logic [N_W-1:0]          n_q, n_d;
  logic signed [SMP_W-1:0] res_i_q, res_i_d;
  logic signed [SMP_W-1:0] res_q_q, res_q_d;

  logic [N_W-1:0]   n_eff;
  logic [N_W-1:0]   seen_inc;
  logic [SUM_W:0]   add_i, add_q;
  logic [SUM_W-1:0] sat_i, sat_q;
  logic             accept;

  always_comb begin
    if (dec_q == '0) begin
      n_eff = N_W'(1);
    end else if (int'(dec_q) > MAX_DECIMATION) begin
      n_eff = N_W'(MAX_DECIMATION);
    end else begin
      n_eff = dec_q;
    end
  end

  assign seen_inc = seen_q + N_W'(1);
  assign add_i    = {1'b0, sum_i_q} + (SUM_W+1)'(sample_i_i);
  assign add_q    = {1'b0, sum_q_q} + (SUM_W+1)'(sample_q_i);
  assign sat_i    = add_i[SUM_W] ? {SUM_W{1'b1}} : add_i[SUM_W-1:0];
  assign sat_q    = add_q[SUM_W] ? {SUM_W{1'b1}} : add_q[SUM_W-1:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    dec_d  = dec_q;
    skip_d = skip_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DECIMATION: dec_d  = cfg_wdata_i;
        REG_SKIP_MODE:  skip_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    sum_i_d   = sum_i_q;
    sum_q_d   = sum_q_q;
    seen_d    = seen_q;
    n_d       = n_q;
    res_i_d   = res_i_q;
    res_q_d   = res_q_q;
    div_req_o = '{start: 1'b0, dividend: sum_q_q, divisor: n_q};
    res_o     = '{valid: 1'b0, i: res_i_q, q: res_q_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (skip_q) begin
            sum_i_d = '0;
            sum_q_d = '0;
            seen_d  = (seen_inc >= n_eff) ? '0 : seen_inc;
            if (seen_q == '0) begin
              res_i_d = to_signed8(sample_i_i);
              res_q_d = to_signed8(sample_q_i);
              state_d = ST_EMIT;
            end
          end else begin
            sum_i_d = sat_i;
            sum_q_d = sat_q;
            if (seen_inc >= n_eff) begin
              // group closes: divide i now, q once i is done
              seen_d    = '0;
              n_d       = n_eff;
              div_req_o = '{start: 1'b1, dividend: sat_i, divisor: n_eff};
              state_d   = ST_DIV_I;
            end else begin
              seen_d = seen_inc;
            end
          end
        end
      end
      ST_DIV_I: begin
        if (div_rsp_i.done) begin
          res_i_d   = to_signed8(sat8(div_rsp_i.quotient));
          div_req_o = '{start: 1'b1, dividend: sum_q_q, divisor: n_q};
          state_d   = ST_DIV_Q;
        end
      end
      ST_DIV_Q: begin
        if (div_rsp_i.done) begin
          res_q_d = to_signed8(sat8(div_rsp_i.quotient));
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          sum_i_d = '0;
          sum_q_d = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dec_q   <= N_W'(1);
      skip_q  <= 1'b0;
      sum_i_q <= '0;
      sum_q_q <= '0;
      seen_q  <= '0;
    end else begin
      state_q <= state_d;
      dec_q   <= dec_d;
      skip_q  <= skip_d;
      sum_i_q <= sum_i_d;
      sum_q_q <= sum_q_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    res_i_q <= res_i_d;
    res_q_q <= res_q_d;
  end

  // the counter is always cleared before it can reach the top code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != {N_W{1'b1}})
    else $error("pair counter out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_I && div_rsp_i.done) |=> (state_q == ST_DIV_Q && !div_rsp_i.done))
    else $error("q division did not follow i division");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && res_ready_i) |=> (state_q == ST_IDLE && sum_i_q == '0))
    else $error("result handoff did not clear the group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |-> (div_req_o.divisor != '0))
    else $error("divider started with zero divisor");

endmodule
